[src/dlmwc_pkg.sv]
// ----------------------------------------------------------------------------
// dlmwc_pkg
// Shared types, widths and constants of the dual-lag multiply-with-carry unit.
// ----------------------------------------------------------------------------
package dlmwc_pkg;

	localparam int WORD_W   = 16;
	localparam int ACC_W    = 32;
	localparam int LAG_N    = 9;
	localparam int TAP_N    = 8;
	localparam int TAP_W    = $clog2(TAP_N);
	localparam int LAG_IDX_W = $clog2(LAG_N);
	localparam int SEED_N   = 18;
	localparam int SEED_PER_GEN = SEED_N / 2;
	localparam int CNT_W    = $clog2(SEED_N + 1);

	localparam logic [WORD_W-1:0] SEED_MULT  = 16'd30903;
	localparam logic [WORD_W-1:0] CARRY_MASK = 16'h7FFF;

	// Command codes
	localparam logic OP_SEED = 1'b0;
	localparam logic OP_NEXT = 1'b1;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ACC_W-1:0]  acc_t;

	// Write/commit controls for one generator's lag bank
	typedef struct packed {
		logic                 clr_oldest; // zero the oldest lag (seed start)
		logic                 wr_carry;   // seed write of the carry
		logic                 wr_lag;     // seed write of a lag
		logic [TAP_W-1:0]     wr_idx;
		word_t                wr_data;
		logic                 commit;     // shift lags, take new sum
		acc_t                 sum;
	} lag_ctrl_t;

	// Tap weights; tap i multiplies lag i before the shift
	function automatic word_t first_weight(input logic [TAP_W-1:0] idx);
		word_t w;
		case (idx)
			3'd0: w = 16'd1941;
			3'd1: w = 16'd1860;
			3'd2: w = 16'd1812;
			3'd3: w = 16'd1776;
			3'd4: w = 16'd1492;
			3'd5: w = 16'd1215;
			3'd6: w = 16'd1066;
			default: w = 16'd12013;
		endcase
		return w;
	endfunction

	function automatic word_t second_weight(input logic [TAP_W-1:0] idx);
		word_t w;
		case (idx)
			3'd0: w = 16'd1111;
			3'd1: w = 16'd2222;
			3'd2: w = 16'd3333;
			3'd3: w = 16'd4444;
			3'd4: w = 16'd5555;
			3'd5: w = 16'd6666;
			3'd6: w = 16'd7777;
			default: w = 16'd9272;
		endcase
		return w;
	endfunction

endpackage

[src/dlmwc_mac.sv]
// ----------------------------------------------------------------------------
// dlmwc_mac
// Shared 16x16 multiply-add with registered 32-bit result.
// ----------------------------------------------------------------------------
module dlmwc_mac
	import dlmwc_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  word_t a,
	input  word_t b,
	input  acc_t  addend,
	output acc_t  acc_q
);

	acc_t prod;

	assign prod = ACC_W'(a) * ACC_W'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= prod + addend;
		end
	end

endmodule

[src/dlmwc_lag_bank.sv]
// ----------------------------------------------------------------------------
// dlmwc_lag_bank
// Nine lagged words and the carry of one generator.
// ----------------------------------------------------------------------------
module dlmwc_lag_bank
	import dlmwc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  lag_ctrl_t        ctrl,
	input  logic [TAP_W-1:0] rd_idx,
	output word_t            rd_lag,
	output word_t            carry_q
);

	word_t lags_q [LAG_N];

	assign rd_lag = lags_q[LAG_IDX_W'(rd_idx)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAG_N; i++) begin
				lags_q[i] <= '0;
			end
			carry_q <= '0;
		end else begin
			if (ctrl.commit) begin
				for (int i = LAG_N - 1; i > 0; i--) begin
					lags_q[i] <= lags_q[i-1];
				end
				lags_q[0] <= ctrl.sum[WORD_W-1:0];
				carry_q   <= ctrl.sum[ACC_W-1:WORD_W];
			end else begin
				if (ctrl.clr_oldest) begin
					lags_q[LAG_N-1] <= '0;
				end
				if (ctrl.wr_lag) begin
					lags_q[LAG_IDX_W'(ctrl.wr_idx)] <= ctrl.wr_data;
				end
				if (ctrl.wr_carry) begin
					carry_q <= ctrl.wr_data & CARRY_MASK;
				end
			end
		end
	end

endmodule

[src/dual_lag_multiply_with_carry_rng_unit.sv]
// Generate: accept, 8 multiply-add taps per generator on one MAC each, commit; the word
//   is valid once committed and the next command is taken after the commit; the result
//   register frees the output side, and a commit waits only while a previous word
//   is still held there.
// Seed: 18 chained steps through generator one's MAC plus drain, only while unseeded.
// Reset: asynchronous, active low; lags and carries clear to zero, unseeded.
// ----------------------------------------------------------------------------
// dual_lag_multiply_with_carry_rng_unit
// Two 16-bit multiply-with-carry generators under a small step sequencer.
// ----------------------------------------------------------------------------
module dual_lag_multiply_with_carry_rng_unit
	import dlmwc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// command transaction
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic        op,
	input  logic [31:0] seed_value,
	// result transaction
	output logic        word_valid,
	input  logic        word_ready,
	output logic [31:0] random_word
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEED = 2'd1;
	localparam logic [1:0] ST_GEN  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             seeded_q;
	logic [31:0]      seed_q;
	logic             word_valid_q;
	logic [31:0]      word_q;

	logic             cmd_take;
	logic             commit;
	logic [TAP_W-1:0] tap;

	// MAC operands
	logic  mac_en;
	word_t a1, b1, a2, b2;
	acc_t  c1, c2, acc1, acc2;

	lag_ctrl_t ctrl1, ctrl2;
	word_t     lag1, lag2, carry1, carry2;

	// seed write bookkeeping: word k of the chain is in acc1 during cnt = k+1
	logic [CNT_W-1:0] seed_word;
	logic             seed_wr;
	logic             seed_to_first;
	logic [CNT_W-1:0] seed_local;

	assign cmd_ready  = (state_q == ST_IDLE);
	assign cmd_take   = cmd_valid && cmd_ready;
	assign word_valid = word_valid_q;
	assign random_word = word_q;

	assign tap    = cnt_q[TAP_W-1:0];
	assign commit = (state_q == ST_DONE) && (!word_valid_q || word_ready);

	// ---------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			seeded_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (cmd_take) begin
						if (op != OP_SEED) begin
							state_q <= ST_GEN;
						end else if (!seeded_q) begin
							state_q <= ST_SEED;
						end
					end
				end
				ST_SEED: begin
					if (cnt_q == CNT_W'(SEED_N)) begin
						state_q  <= ST_IDLE;
						seeded_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_GEN: begin
					if (cnt_q == CNT_W'(TAP_N - 1)) begin
						state_q <= ST_DONE;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_DONE: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			seed_q <= seed_value;
		end
	end

	// Output register: holds one word while the next command runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= 1'b0;
		end else if (commit) begin
			word_valid_q <= 1'b1;
		end else if (word_ready) begin
			word_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			word_q <= {acc1[WORD_W-1:0], acc2[WORD_W-1:0]};
		end
	end

	// ---------------------------------------------------------------------
	// MAC operand select. Seeding runs x = 30903*w + (x >> 16) on MAC one;
	// the first step takes x and w straight from the seed (bit 31 dropped).
	// Generation accumulates weight*lag over the eight taps (lags 0..7) on top of
	// the carry.
	// ---------------------------------------------------------------------
	always_comb begin
		mac_en = 1'b0;
		a1 = lag1;
		b1 = first_weight(tap);
		c1 = (cnt_q == '0) ? ACC_W'(carry1) : acc1;
		a2 = lag2;
		b2 = second_weight(tap);
		c2 = (cnt_q == '0) ? ACC_W'(carry2) : acc2;
		if (state_q == ST_SEED) begin
			mac_en = (cnt_q != CNT_W'(SEED_N));
			b1 = SEED_MULT;
			if (cnt_q == '0) begin
				a1 = seed_q[WORD_W-1:0];
				c1 = ACC_W'(seed_q[30:WORD_W]);
			end else begin
				a1 = acc1[WORD_W-1:0];
				c1 = ACC_W'(acc1[ACC_W-1:WORD_W]);
			end
		end else if (state_q == ST_GEN) begin
			mac_en = 1'b1;
		end
	end

	dlmwc_mac u_mac1 (
		.clk    (clk),
		.en     (mac_en),
		.a      (a1),
		.b      (b1),
		.addend (c1),
		.acc_q  (acc1)
	);

	dlmwc_mac u_mac2 (
		.clk    (clk),
		.en     (mac_en && (state_q == ST_GEN)),
		.a      (a2),
		.b      (b2),
		.addend (c2),
		.acc_q  (acc2)
	);

	// ---------------------------------------------------------------------
	// Seed word placement: words 0..8 go to generator one (carry, lags 0..7),
	// words 9..17 to generator two in the same order.
	// ---------------------------------------------------------------------
	assign seed_word     = cnt_q - 1'b1;
	assign seed_wr       = (state_q == ST_SEED) && (cnt_q != '0);
	assign seed_to_first = (seed_word < CNT_W'(SEED_PER_GEN));
	assign seed_local    = seed_to_first ? seed_word : seed_word - CNT_W'(SEED_PER_GEN);

	always_comb begin
		ctrl1            = '0;
		ctrl1.clr_oldest = (state_q == ST_SEED) && (cnt_q == '0);
		ctrl1.wr_data    = acc1[WORD_W-1:0];
		ctrl1.wr_idx     = TAP_W'(seed_local - 1'b1);
		ctrl1.commit     = commit;
		ctrl1.sum        = acc1;
		ctrl2            = ctrl1;
		ctrl2.sum        = acc2;
		ctrl1.wr_carry   = seed_wr && seed_to_first && (seed_local == '0);
		ctrl1.wr_lag     = seed_wr && seed_to_first && (seed_local != '0);
		ctrl2.wr_carry   = seed_wr && !seed_to_first && (seed_local == '0);
		ctrl2.wr_lag     = seed_wr && !seed_to_first && (seed_local != '0);
	end

	dlmwc_lag_bank u_bank1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl1),
		.rd_idx  (tap),
		.rd_lag  (lag1),
		.carry_q (carry1)
	);

	dlmwc_lag_bank u_bank2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl2),
		.rd_idx  (tap),
		.rd_lag  (lag2),
		.carry_q (carry2)
	);

endmodule
